// ----- hw/rtl/sit_pkg.sv -----
// ----------------------------------------------------------------------------
// sit_pkg: shared types and constants of the sorted insertion table
// Request and status codes, field widths and the control bundle that the
// sequencer broadcasts to every cell of the row.
// ----------------------------------------------------------------------------
package sit_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned DataW      = 32;
  localparam int unsigned ReqW       = 2;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned PosW       = 5;

  // request codes
  localparam logic [ReqW-1:0] ReqInsert = 2'd0;
  localparam logic [ReqW-1:0] ReqSearch = 2'd1;
  localparam logic [ReqW-1:0] ReqClear  = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] StatDone     = 2'd0;
  localparam logic [StatusW-1:0] StatFull     = 2'd1;
  localparam logic [StatusW-1:0] StatNotFound = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_APPLY
  } sit_state_e;

  // broadcast from the sequencer to all cells
  typedef struct packed {
    logic                    cmp_en;
    logic                    ins_en;
    logic signed [DataW-1:0] value;
  } sit_ctrl_t;

endpackage

// ----- hw/rtl/sit_cell.sv -----
// ----------------------------------------------------------------------------
// sit_cell: one slot of the sorted row
// Holds one entry, compares it against the broadcast value and on insert
// either keeps it, takes the new value, or takes its left neighbor's entry.
// ----------------------------------------------------------------------------
module sit_cell import sit_pkg::*; #(
  parameter int unsigned Depth   = TableDepth,
  parameter int unsigned CellIdx = 0,
  localparam int unsigned CntW   = $clog2(Depth + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  sit_ctrl_t               ctrl_i,
  input  logic [CntW-1:0]         count_i,
  input  logic                    left_lt_i,
  input  logic signed [DataW-1:0] left_entry_i,
  output logic                    lt_o,
  output logic signed [DataW-1:0] entry_o,
  output logic                    bnd_o,
  output logic                    hit_o
);

  logic                    valid;
  logic                    lt_q, lt_d;
  logic                    eq_q, eq_d;
  logic signed [DataW-1:0] entry_q, entry_d;

  assign valid = CntW'(CellIdx) < count_i;

  // compare the stored entry with the broadcast value
  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (ctrl_i.cmp_en) begin
      lt_d = valid && (entry_q < ctrl_i.value);
      eq_d = valid && (entry_q == ctrl_i.value);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  // first slot that is not smaller: left neighbor smaller, this one not
  assign bnd_o = !lt_q && left_lt_i;
  assign hit_o = bnd_o && eq_q;

  // take the new value at the boundary, shift right of it
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en) begin
      if (bnd_o) begin
        entry_d = ctrl_i.value;
      end else if (!lt_q) begin
        entry_d = left_entry_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign lt_o    = lt_q;
  assign entry_o = entry_q;

endmodule

// ----- hw/rtl/sit_encoder.sv -----
// ----------------------------------------------------------------------------
// sit_encoder: one-hot to index
// Turns the boundary flag of the cell row into the slot index.
// ----------------------------------------------------------------------------
module sit_encoder import sit_pkg::*; #(
  parameter int unsigned Depth  = TableDepth,
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic [Depth-1:0] onehot_i,
  output logic [IdxW-1:0]  idx_o
);

  // OR together the indexes of the set flags
  always_comb begin
    idx_o = '0;
    for (int unsigned i = 0; i < Depth; i++) begin
      if (onehot_i[i]) begin
        idx_o = idx_o | IdxW'(i);
      end
    end
  end

endmodule

// ----- hw/rtl/sorted_insertion_table_top.sv -----
// An item is accepted in idle, compared in every cell, then applied: the shift in
//   the cell row and the registered result. A new item is taken only once the last
//   one is applied, and apply waits while a stalled result still holds the output.
// An item is taken while an earlier result still waits on the output.
// Reset clears the fill count and all control state at once; entries need none.
// ----------------------------------------------------------------------------
// sorted_insertion_table_top: ascending table of signed values
// A row of compare-and-shift cells that inserts, searches or clears.
// ----------------------------------------------------------------------------
module sorted_insertion_table_top import sit_pkg::*; #(
  parameter int unsigned Depth  = TableDepth,
  localparam int unsigned CntW  = $clog2(Depth + 1),
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic signed [DataW-1:0] value_in_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic [PosW-1:0]         position_o,
  output logic [PosW-1:0]         fill_count_o
);

  sit_state_e state_q, state_d;

  logic [ReqW-1:0]         req_q, req_d;
  logic signed [DataW-1:0] val_q, val_d;
  logic [CntW-1:0]         count_q, count_d;

  logic                    out_valid_q, out_valid_d;
  logic [StatusW-1:0]      status_q, status_d;
  logic [PosW-1:0]         position_q, position_d;
  logic [PosW-1:0]         fill_q, fill_d;

  logic                    accept;
  logic                    apply_go;
  logic                    full;
  sit_ctrl_t               ctrl;

  logic [Depth-1:0]        lt;
  logic [Depth-1:0]        bnd;
  logic [Depth-1:0]        hit;
  logic signed [DataW-1:0] entry [Depth];
  logic [IdxW-1:0]         bnd_idx;

  assign accept   = in_valid_i && in_ready_o;
  assign apply_go = (state_q == ST_APPLY) && (!out_valid_q || out_ready_i);
  assign full     = count_q == CntW'(Depth);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = ST_CMP;
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: if (apply_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o  = 1'b0;
    ctrl.cmp_en = 1'b0;
    ctrl.ins_en = 1'b0;
    ctrl.value  = val_q;
    unique case (state_q)
      ST_IDLE:  in_ready_o  = 1'b1;
      ST_CMP:   ctrl.cmp_en = 1'b1;
      ST_APPLY: ctrl.ins_en = apply_go && (req_q == ReqInsert) && !full;
      default:  in_ready_o  = 1'b0;
    endcase
  end

  // capture the item
  always_comb begin
    req_d = req_q;
    val_d = val_q;
    if (accept) begin
      req_d = req_type_i;
      val_d = value_in_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    val_q <= val_d;
  end

  // cell row
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic                    left_lt;
    logic signed [DataW-1:0] left_entry;

    if (g == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = val_q;
    end else begin : g_body
      assign left_lt    = lt[g-1];
      assign left_entry = entry[g-1];
    end

    sit_cell #(
      .Depth   (Depth),
      .CellIdx (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .count_i      (count_q),
      .left_lt_i    (left_lt),
      .left_entry_i (left_entry),
      .lt_o         (lt[g]),
      .entry_o      (entry[g]),
      .bnd_o        (bnd[g]),
      .hit_o        (hit[g])
    );
  end

  sit_encoder #(
    .Depth (Depth)
  ) u_enc (
    .onehot_i (bnd),
    .idx_o    (bnd_idx)
  );

  // result and fill count
  always_comb begin
    count_d     = count_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    position_d  = position_q;
    fill_d      = fill_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (apply_go) begin
      status_d   = StatDone;
      position_d = '0;
      case (req_q)
        ReqInsert: begin
          if (full) begin
            status_d = StatFull;
          end else begin
            position_d = PosW'(bnd_idx);
            count_d    = count_q + CntW'(1);
          end
        end
        ReqSearch: begin
          if (|hit) begin
            position_d = PosW'(bnd_idx);
          end else begin
            status_d = StatNotFound;
          end
        end
        ReqClear: count_d = '0;
        default:  count_d = count_q;
      endcase
      fill_d      = PosW'(count_d);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q   <= status_d;
    position_q <= position_d;
    fill_q     <= fill_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign position_o   = position_q;
  assign fill_count_o = fill_q;

endmodule

// ----- hw/rtl/sit_checker.sv -----
// ----------------------------------------------------------------------------
// sit_checker: port-level checks of the sorted insertion table
// Watches the handshakes and the result fields, attached by bind.
// ----------------------------------------------------------------------------
module sit_checker import sit_pkg::*; #(
  parameter int unsigned Depth = TableDepth
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_o,
  input logic                    out_valid_o,
  input logic                    out_ready_i,
  input logic [StatusW-1:0]      status_o,
  input logic [PosW-1:0]         position_o,
  input logic [PosW-1:0]         fill_count_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(position_o) && $stable(fill_count_o))
    else $error("stalled result changed");

  // an accepted item does not show up as a result in the next cycle
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared one cycle after accept");

  // reject only with a full table
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatFull |-> fill_count_o == PosW'(Depth))
    else $error("insert rejected with free slots");

  // a missed search or a reject reports slot zero
  a_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StatNotFound || status_o == StatFull)
      |-> position_o == '0)
    else $error("nonzero position on failed item");

  // a done insert or hit lies inside the fill
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == StatDone && Depth < 32
      |-> position_o <= fill_count_o)
    else $error("position beyond fill count");

endmodule

bind sorted_insertion_table_top sit_checker #(.Depth(Depth)) u_sit_checker (.*);

// ----- sim/sorted_insertion_table_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_insertion_table_checker: result checker for the sorted table
// Watches the request and result channels, keeps its own ascending table,
// queues the answer each accepted item should give and compares every
// accepted result field by field against the oldest queued answer.
// ----------------------------------------------------------------------------
module sorted_insertion_table_checker import sit_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [ReqW-1:0]         req_type_i,
  input  logic signed [DataW-1:0] value_in_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [StatusW-1:0]      status_i,
  input  logic [PosW-1:0]         position_i,
  input  logic [PosW-1:0]         fill_count_i,
  output int                      fail_count_o,
  output int                      pending_o,
  output int                      checked_o,
  output int                      full_rejects_o,
  output int                      search_hits_o
);

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [PosW-1:0]    position;
    logic [PosW-1:0]    fill;
  } table_answer_t;

  // shadow copy of the table
  logic signed [DataW-1:0] shadow_entries [TableDepth];
  int unsigned             shadow_count;

  table_answer_t answer_q [$];
  table_answer_t want;
  int            mismatch_cnt;
  int            pending_cnt;
  int            checked_cnt;
  int            full_cnt;
  int            hit_cnt;

  assign fail_count_o   = mismatch_cnt;
  assign pending_o      = pending_cnt;
  assign checked_o      = checked_cnt;
  assign full_rejects_o = full_cnt;
  assign search_hits_o  = hit_cnt;

  // apply one request to the shadow table and return the answer it gives
  function automatic table_answer_t table_request(input logic [ReqW-1:0] req,
                                                  input logic signed [DataW-1:0] val);
    table_answer_t ans;
    int unsigned   slot;
    ans.status   = StatDone;
    ans.position = '0;
    slot = 0;
    // first stored entry that is not smaller than val
    while (slot < shadow_count && shadow_entries[slot] < val) slot++;
    case (req)
      ReqInsert: begin
        if (shadow_count >= TableDepth) begin
          ans.status = StatFull;
        end else begin
          for (int k = shadow_count; k > slot; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[slot] = val;
          shadow_count++;
          ans.position = slot[PosW-1:0];
        end
      end
      ReqSearch: begin
        if (slot < shadow_count && shadow_entries[slot] == val) begin
          ans.position = slot[PosW-1:0];
          hit_cnt++;
        end else begin
          ans.status = StatNotFound;
        end
      end
      ReqClear: begin
        shadow_count = 0;
      end
      default: begin
        // unused code: table untouched
      end
    endcase
    ans.fill = shadow_count[PosW-1:0];
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, exp_val);
    mismatch_cnt++;
  endtask

  // compare results first, then predict the item taken at the same edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      answer_q.delete();
      shadow_count = 0;
      mismatch_cnt = 0;
      pending_cnt  = 0;
      checked_cnt  = 0;
      full_cnt     = 0;
      hit_cnt      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("result with no item pending", status_i, -1);
        end else begin
          want = answer_q.pop_front();
          checked_cnt++;
          if (want.status == StatFull) full_cnt++;
          if (status_i !== want.status) report_mismatch("status", status_i, want.status);
          if (position_i !== want.position)
            report_mismatch("position", position_i, want.position);
          if (fill_count_i !== want.fill)
            report_mismatch("fill_count", fill_count_i, want.fill);
        end
      end
      if (in_valid_i && in_ready_i) answer_q.push_back(table_request(req_type_i, value_in_i));
      pending_cnt = answer_q.size();
    end
  end

endmodule

// ----- sim/tb_sorted_insertion_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_insertion_table_top: testbench of the sorted insertion table
// Drives directed inserts, searches and clears around the table extremes,
// then random request mixes under several idle and stall settings, with a
// long output hold-off; a side checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_sorted_insertion_table_top;
  import sit_pkg::*;

  localparam logic [ReqW-1:0]         ReqUnused = 2'd3;
  localparam logic signed [DataW-1:0] ValMax    = 32'sh7fff_ffff;
  localparam logic signed [DataW-1:0] ValMin    = 32'sh8000_0000;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [ReqW-1:0]         req_type = ReqInsert;
  logic signed [DataW-1:0] value_in = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [StatusW-1:0]      status;
  logic [PosW-1:0]         position;
  logic [PosW-1:0]         fill_count;

  int fail_cnt, pending, checked, full_rejects, search_hits;

  // sender and receiver knobs
  int send_idle_pct = 0;
  int rx_stall_pct  = 0;
  int hold_off_len  = 0;
  int hold_left     = 0;

  // recent insert values, reused so searches hit
  logic signed [DataW-1:0] ins_hist [32];
  int hist_n = 0;
  int n_ins = 0, n_search = 0, n_clear = 0, n_unused = 0;

  always #5 clk = ~clk;

  sorted_insertion_table_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .req_type_i  (req_type),
    .value_in_i  (value_in),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .position_o  (position),
    .fill_count_o(fill_count)
  );

  sorted_insertion_table_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .req_type_i    (req_type),
    .value_in_i    (value_in),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .status_i      (status),
    .position_i    (position),
    .fill_count_i  (fill_count),
    .fail_count_o  (fail_cnt),
    .pending_o     (pending),
    .checked_o     (checked),
    .full_rejects_o(full_rejects),
    .search_hits_o (search_hits)
  );

  // receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off_len != 0) begin
      hold_left    = hold_off_len;
      hold_off_len = 0;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(input logic [ReqW-1:0] req, input logic signed [DataW-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= req;
    value_in <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (req)
      ReqInsert: n_ins++;
      ReqSearch: n_search++;
      ReqClear:  n_clear++;
      default:   n_unused++;
    endcase
  endtask

  // drop valid and wait for every outstanding result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic rand_value(input bit prefer_hist, output logic signed [DataW-1:0] val);
    int pick;
    pick = $urandom_range(9);
    if (prefer_hist && hist_n != 0 && pick < 5) pick = 4;
    case (pick)
      0, 1, 2: begin
        val = $urandom_range(16);
        val = val - 8;
      end
      3: begin
        case ($urandom_range(3))
          0:       val = ValMin;
          1:       val = ValMax;
          2:       val = '0;
          default: val = -1;
        endcase
      end
      4, 5: begin
        if (hist_n == 0) val = $urandom();
        else val = ins_hist[$urandom_range((hist_n < 32) ? hist_n - 1 : 31)];
      end
      default: val = $urandom();
    endcase
  endtask

  task automatic rand_item(output logic [ReqW-1:0] req, output logic signed [DataW-1:0] val);
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) req = ReqInsert;
    else if (roll < 92) req = ReqSearch;
    else if (roll < 96) req = ReqClear;
    else req = ReqUnused;
    rand_value(req == ReqSearch, val);
    if (req == ReqInsert) begin
      ins_hist[hist_n % 32] = val;
      hist_n++;
    end
  endtask

  // one random phase at the given idle and stall rates
  task automatic run_phase(input int n_items, input int tx_pct, input int rx_pct,
                           input bit with_hold);
    logic [ReqW-1:0]         req;
    logic signed [DataW-1:0] val;
    int                      sent;
    bit                      held;
    sent = 0;
    held = 1'b0;
    send_idle_pct = tx_pct;
    rx_stall_pct  = rx_pct;
    while (sent < n_items) begin
      if (with_hold && !held && sent == 60) begin
        hold_off_len = 300;
        held         = 1'b1;
      end
      rand_item(req, val);
      send_item(req, val);
      if (req != ReqUnused) sent++;
    end
    wait_drained();
  endtask

  // run limit
  initial begin
    #2_000_000;
    $display("FAIL sorted_insertion_table_top");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty table, extremes, duplicates, full table, clear
    send_item(ReqSearch, 32'sd5);
    send_item(ReqUnused, 32'sd7);
    send_item(ReqInsert, 32'sd0);
    send_item(ReqInsert, ValMax);
    send_item(ReqInsert, ValMin);
    send_item(ReqInsert, 32'sd0);
    send_item(ReqInsert, -32'sd1);
    send_item(ReqInsert, 32'sd1);
    send_item(ReqInsert, 32'sh5555_5555);
    send_item(ReqInsert, 32'shAAAA_AAAA);
    send_item(ReqSearch, ValMin);
    send_item(ReqSearch, ValMax);
    send_item(ReqSearch, 32'sd0);
    send_item(ReqSearch, 32'sd2);
    for (int k = 0; k < 8; k++) send_item(ReqInsert, ValMax - k);
    send_item(ReqInsert, 32'sd3);
    send_item(ReqSearch, ValMax - 3);
    send_item(ReqClear, 32'sd0);
    send_item(ReqSearch, 32'sd0);
    send_item(ReqUnused, ValMin);
    wait_drained();

    // random phases; the first one carries the long output hold-off
    run_phase(400, 0, 0, 1'b1);
    run_phase(340, 72, 0, 1'b0);
    run_phase(340, 0, 72, 1'b0);
    run_phase(340, 34, 34, 1'b0);
    run_phase(330, 0, 0, 1'b0);

    repeat (20) @(posedge clk);
    $display("Covered %0d inserts, %0d searches, %0d clears, %0d unused codes",
             n_ins, n_search, n_clear, n_unused);
    $display("Checked %0d results: %0d full-table rejects, %0d search hits",
             checked, full_rejects, search_hits);
    if (fail_cnt == 0) begin
      $display("PASS sorted_insertion_table_top");
    end else begin
      $display("FAIL sorted_insertion_table_top");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/sit_pkg.sv
hw/rtl/sit_cell.sv
hw/rtl/sit_encoder.sv
hw/rtl/sorted_insertion_table_top.sv
hw/rtl/sit_checker.sv
sim/sorted_insertion_table_checker.sv
sim/tb_sorted_insertion_table_top.sv
